[sv/icpa_pkg.sv]
// Shared types and constants for the interrupt controller port access block.
package icpa_pkg;

	// Command word bits.
	localparam int unsigned ICW1_INIT_BIT     = 4;
	localparam int unsigned ICW1_SINGLE_BIT   = 1;
	localparam int unsigned ICW1_NEED_ICW4    = 0;
	localparam int unsigned OCW3_SELECT_BIT   = 3;
	localparam int unsigned OCW2_EOI_BIT      = 5;
	localparam int unsigned OCW2_SPECIFIC_BIT = 6;
	localparam logic [7:0]  VECTOR_MASK       = 8'hF8;

	// Initialization step codes.
	localparam logic [2:0] STEP_READY = 3'd0;
	localparam logic [2:0] STEP_ICW2  = 3'd2;
	localparam logic [2:0] STEP_ICW3  = 3'd3;
	localparam logic [2:0] STEP_ICW4  = 3'd4;

	// Read select codes (OCW3).
	localparam logic [1:0] RSEL_NONE = 2'd0;
	localparam logic [1:0] RSEL_IRR  = 2'd2;
	localparam logic [1:0] RSEL_ISR  = 2'd3;

	// Access kind.
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_READ   = 1'b1;
	localparam logic PORT_CMD  = 1'b0;
	localparam logic PORT_DATA = 1'b1;

	typedef struct packed {
		logic       op;
		logic       port_sel;
		logic [7:0] write_data;
		logic [7:0] pending_requests;
		logic [7:0] ack_set_mask;
	} access_t;

	typedef struct packed {
		logic [7:0] init_word;
		logic [2:0] init_step;
		logic [7:0] mask_reg;
		logic [7:0] vector_offset_reg;
		logic [7:0] cascade_word;
		logic [7:0] mode_word;
		logic [1:0] read_select;
		logic [7:0] in_service_reg;
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] irq_mask;
		logic [7:0] vector_base;
		logic [7:0] in_service;
		logic [2:0] init_stage;
	} result_t;

endpackage

[sv/interrupt_controller_port_access.sv]
// Top level of the 8259-style interrupt controller bus port access block.
//
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid/s_tready    one bus access transaction
//  m_*       out        m_tvalid/m_tready    one result transaction per access
//  cfg_*     in         cfg_valid/cfg_ready  data port lock register write
//
// Each access is captured in an input register (stage 1), evaluated by the
// core logic against the controller state, and the result is written to an
// output register (stage 2) on the same edge that updates the state. One
// access is accepted every cycle while the output is not stalled. When
// m_tready is low the output register holds, stage 1 fills, and then
// s_tready falls. Reset clears the controller state, the lock register
// and both valid flags. The configuration channel is always ready.
module interrupt_controller_port_access (
	input  logic        clk,
	input  logic        arst_n,
	// Access input.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // write_data, pending_requests, ack_set_mask
	input  logic [1:0]  s_tuser,  // op, port_sel
	// Result output.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // read_data, irq_mask, vector_base,
	                              // in_service, init_stage, zero fill
	// Configuration write.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data  // data_port_locked
);

	icpa_pkg::access_t     acc_s1;
	logic                  valid_s1;
	icpa_pkg::result_t     res_s2;
	logic                  valid_s2;
	logic                  rd_write_s2;
	icpa_pkg::ctrl_state_t state_q;
	icpa_pkg::ctrl_state_t state_nxt;
	icpa_pkg::result_t     res_nxt;
	logic                  locked_q;

	logic s2_free;
	logic s1_move;

	assign s2_free   = !valid_s2 || m_tready;
	assign s1_move   = valid_s1 && s2_free;
	assign s_tready  = !valid_s1 || s1_move;
	assign cfg_ready = 1'b1;

	// Stage 1 valid and the lock register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			locked_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (cfg_valid && cfg_ready) begin
				locked_q <= cfg_data;
			end
		end
	end

	// Stage 1 payload needs no reset.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			acc_s1.op               <= s_tuser[0];
			acc_s1.port_sel         <= s_tuser[1];
			acc_s1.write_data       <= s_tdata[7:0];
			acc_s1.pending_requests <= s_tdata[15:8];
			acc_s1.ack_set_mask     <= s_tdata[23:16];
		end
	end

	icpa_core u_core (
		.acc    (acc_s1),
		.locked (locked_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// Controller state advances only when an access leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				state_q <= state_nxt;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_s2      <= res_nxt;
			rd_write_s2 <= (acc_s1.op == icpa_pkg::OP_WRITE);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'd0, res_s2.init_stage, res_s2.in_service,
	                   res_s2.vector_base, res_s2.irq_mask, res_s2.read_data};

	// A write access never returns read data.
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rd_write_s2 |-> res_s2.read_data == 8'd0)
		else $error("write access produced nonzero read data");

	// The vector offset always has its low three bits clear.
	a_vector_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.vector_base[2:0] == 3'd0)
		else $error("vector base not aligned");

	// Initialization step is only ever one of the defined steps.
	a_step_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.init_step == icpa_pkg::STEP_READY ||
		state_q.init_step == icpa_pkg::STEP_ICW2 ||
		state_q.init_step == icpa_pkg::STEP_ICW3 ||
		state_q.init_step == icpa_pkg::STEP_ICW4)
		else $error("initialization step left the defined set");

	// A held access in stage 1 is not dropped while the output stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |=> valid_s1 && $stable(acc_s1))
		else $error("stalled access lost from stage 1");

endmodule

[sv/icpa_core.sv]
// Combinational next-state and result logic for one bus access.
module icpa_core (
	input  icpa_pkg::access_t     acc,
	input  logic                  locked,
	input  icpa_pkg::ctrl_state_t cur,
	output icpa_pkg::ctrl_state_t nxt,
	output icpa_pkg::result_t     res
);

	logic [7:0] isr_acked;
	logic [7:0] rd;
	logic [7:0] wd;

	always_comb begin
		wd        = acc.write_data;
		isr_acked = cur.in_service_reg | acc.ack_set_mask;
		nxt       = cur;
		nxt.in_service_reg = isr_acked;
		rd        = 8'd0;

		if (acc.port_sel == icpa_pkg::PORT_CMD) begin
			if (acc.op == icpa_pkg::OP_READ) begin
				case (cur.read_select)
					icpa_pkg::RSEL_IRR: rd = acc.pending_requests;
					icpa_pkg::RSEL_ISR: rd = isr_acked;
					default:            nxt.read_select = icpa_pkg::RSEL_NONE;
				endcase
			end else if (wd[icpa_pkg::ICW1_INIT_BIT]) begin
				nxt.init_word = wd;
				nxt.init_step = icpa_pkg::STEP_ICW2;
				nxt.mask_reg  = 8'd0;
			end else if (wd[icpa_pkg::OCW3_SELECT_BIT]) begin
				nxt.read_select = wd[1:0];
			end else if (wd[icpa_pkg::OCW2_EOI_BIT]) begin
				if (wd[icpa_pkg::OCW2_SPECIFIC_BIT]) begin
					nxt.in_service_reg = isr_acked & ~(8'd1 << wd[2:0]);
				end else begin
					// Clearing the lowest set bit: x & (x - 1).
					nxt.in_service_reg = isr_acked & (isr_acked - 8'd1);
				end
			end
		end else begin
			if (acc.op == icpa_pkg::OP_READ) begin
				if (!locked) begin
					rd = cur.mask_reg;
				end
			end else begin
				case (cur.init_step)
					icpa_pkg::STEP_READY: begin
						if (!locked) begin
							nxt.mask_reg = wd;
						end
					end
					icpa_pkg::STEP_ICW2: begin
						nxt.vector_offset_reg = wd & icpa_pkg::VECTOR_MASK;
						if (!cur.init_word[icpa_pkg::ICW1_SINGLE_BIT]) begin
							nxt.init_step = icpa_pkg::STEP_ICW3;
						end else if (cur.init_word[icpa_pkg::ICW1_NEED_ICW4]) begin
							nxt.init_step = icpa_pkg::STEP_ICW4;
						end else begin
							nxt.mode_word = 8'd0;
							nxt.init_step = icpa_pkg::STEP_READY;
						end
					end
					icpa_pkg::STEP_ICW3: begin
						nxt.cascade_word = wd;
						if (cur.init_word[icpa_pkg::ICW1_NEED_ICW4]) begin
							nxt.init_step = icpa_pkg::STEP_ICW4;
						end else begin
							nxt.mode_word = 8'd0;
							nxt.init_step = icpa_pkg::STEP_READY;
						end
					end
					icpa_pkg::STEP_ICW4: begin
						nxt.mode_word = wd;
						nxt.init_step = icpa_pkg::STEP_READY;
					end
					default: begin
						// Unused steps ignore data writes.
					end
				endcase
			end
		end

		res.read_data   = rd;
		res.irq_mask    = nxt.mask_reg;
		res.vector_base = nxt.vector_offset_reg;
		res.in_service  = nxt.in_service_reg;
		res.init_stage  = nxt.init_step;
	end

endmodule
